>>> src/pwsd_pkg.sv
// package: types, constants and helpers of the pid controller with settle detection
`timescale 1ns / 1ps
`default_nettype none
package pwsd_pkg;

  localparam int TICK_MS      = 10;
  localparam int SETTLE_MS    = 200;
  localparam int TIMEOUT_MS   = 5000;
  localparam int OUT_SCALE_Q8 = 256;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;
  localparam int ACC_W   = 24;
  localparam int TMR_W   = 17;
  localparam int SUM_W   = 42;
  localparam int DRIVE_W = 32;
  localparam int MA_W    = 17;
  localparam int MB_W    = 32;
  localparam int MP_W    = MA_W + MB_W;

  localparam logic [TMR_W-1:0] TIMER_MAX = '1;

  localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INT_ZONE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_INT_LIM    = 3'd5;
  localparam logic [IDX_W-1:0] REG_ERR_TOL    = 3'd6;
  localparam logic [IDX_W-1:0] REG_DERIV_TOL  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DTERM,
    ST_SIGN,
    ST_ITERM,
    ST_ADDI,
    ST_CLAMP,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MSEL_P,
    MSEL_D,
    MSEL_I,
    MSEL_S
  } msel_t;

  typedef struct packed {
    msel_t msel;
    logic  prep;
    logic  dterm;
    logic  sign;
    logic  iterm;
    logic  addi;
    logic  clamp;
    logic  finish;
  } ctrl_t;

  function automatic logic [TMR_W-1:0] tmr_add(input logic [TMR_W-1:0] t);
    logic [TMR_W:0] n;
    n = {1'b0, t} + (TMR_W+1)'(TICK_MS);
    return (n > {1'b0, TIMER_MAX}) ? TIMER_MAX : n[TMR_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/pwsd_in_if.sv
// interface: request channel carrying one error sample
`timescale 1ns / 1ps
`default_nettype none
interface pwsd_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] error_sample;
  logic              restart;

  modport source (output valid, output error_sample, output restart, input ready);
  modport sink (input valid, input error_sample, input restart, output ready);
endinterface
`default_nettype wire

>>> src/pwsd_out_if.sv
// interface: result channel carrying drive and arrived flag
`timescale 1ns / 1ps
`default_nettype none
interface pwsd_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] drive;
  logic              arrived;

  modport source (output valid, output drive, output arrived, input ready);
  modport sink (input valid, input drive, input arrived, output ready);
endinterface
`default_nettype wire

>>> src/pid_with_settle_detect.sv
// top level: pid controller with integral zone, clamps and settle detection
//
//   channel  role    fields                       handshake
//   in_if    sink    error_sample, restart        valid / ready
//   out_if   source  drive, arrived               valid / ready
//   cfg_*    write   cfg_index, cfg_wdata         cfg_we, no wait
//
// each request passes the sequencer steps prep, dterm, sign, iterm, addi, clamp,
// scale and done, set by the single shared multiplier used for p, d, i and output scaling;
// the sequencer is through with one request before it takes the next
// in_if.ready is high only while idle; a result waits in the output register
// and a new request may be taken while it waits; a stalled output holds
// the sequencer in its last step
// reset is synchronous and clears the controller state, the configuration
// registers and the pending result
`timescale 1ns / 1ps
`default_nettype none
module pid_with_settle_detect (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  pwsd_in_if.sink                             in_if,
  pwsd_out_if.source                          out_if,
  input  wire logic                           cfg_we,
  input  wire logic [pwsd_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [pwsd_pkg::CFG_W-1:0]     cfg_wdata
);
  import pwsd_pkg::*;

  // configuration
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0] drive_lim_r;
  logic [14:0] int_zone_r;
  logic [22:0] int_lim_r;
  logic [14:0] err_tol_r;
  logic [30:0] deriv_tol_r;

  // controller state
  logic signed [ERR_W-1:0] last_r, last_nxt;
  logic                    first_r, first_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [TMR_W-1:0]        settle_r, settle_nxt;
  logic [TMR_W-1:0]        timeout_r, timeout_nxt;
  logic                    arr_r, arr_nxt;

  // working registers
  logic signed [ERR_W-1:0] e_r;
  logic                    restart_r;
  logic signed [ERR_W:0]   diff_r, diff_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    d_ok_r, d_ok_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                    out_arrived_r;

  ctrl_t ctrl;
  logic  idle;
  logic  in_acc;
  logic  out_free;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod_r;

  logic [ERR_W:0]          e_mag;
  logic                    on_tgt;
  logic signed [SUM_W-1:0] prod_s;

  assign in_acc   = in_if.valid && idle;
  assign out_free = !out_valid_r || out_if.ready;

  assign in_if.ready    = idle;
  assign out_if.valid   = out_valid_r;
  assign out_if.drive   = out_drive_r;
  assign out_if.arrived = out_arrived_r;

  pwsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  always_comb begin
    mul_a = MA_W'(gain_p_r);
    mul_b = MB_W'(e_r);
    case (ctrl.msel)
      MSEL_P: begin
        mul_a = MA_W'(gain_p_r);
        mul_b = MB_W'(e_r);
      end
      MSEL_D: begin
        mul_a = MA_W'(gain_d_r);
        mul_b = MB_W'(diff_r);
      end
      MSEL_I: begin
        mul_a = MA_W'(gain_i_r);
        mul_b = MB_W'(acc_r);
      end
      MSEL_S: begin
        mul_a = MA_W'(OUT_SCALE_Q8);
        mul_b = sum_r[MB_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pwsd_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign e_mag  = e_r[ERR_W-1] ? (ERR_W+1)'(-$signed({e_r[ERR_W-1], e_r}))
                               : {1'b0, e_r};
  assign on_tgt = e_mag <= {2'b0, err_tol_r};
  assign prod_s = prod_r[SUM_W-1:0];

  always_comb begin
    logic signed [ACC_W:0]   s;
    logic signed [ACC_W:0]   lim;
    logic signed [33:0]      dv;
    logic [33:0]             dmag;
    logic                    first_eff;
    logic                    acc_neg, acc_zero, e_zero;
    logic signed [SUM_W-1:0] dlim;
    logic [TMR_W-1:0]        st;
    logic [TMR_W-1:0]        tt;
    logic                    ar;

    last_nxt    = last_r;
    first_nxt   = first_r;
    acc_nxt     = acc_r;
    settle_nxt  = settle_r;
    timeout_nxt = timeout_r;
    arr_nxt     = arr_r;
    diff_nxt    = diff_r;
    sum_nxt     = sum_r;
    d_ok_nxt    = d_ok_r;

    first_eff = restart_r || first_r;
    s   = $signed({acc_r[ACC_W-1], acc_r}) + (ACC_W+1)'(e_r);
    lim = $signed({2'b0, int_lim_r});
    dv   = prod_r[33:0];
    dmag = dv[33] ? 34'(-dv) : dv;
    acc_neg  = acc_r[ACC_W-1];
    acc_zero = (acc_r == '0);
    e_zero   = (e_r == '0);
    dlim = $signed({11'b0, drive_lim_r});
    st = settle_r;
    tt = timeout_r;
    ar = arr_r;

    if (ctrl.prep) begin
      last_nxt  = e_r;
      first_nxt = 1'b0;
      diff_nxt  = first_eff ? '0
                            : $signed({e_r[ERR_W-1], e_r}) - $signed({last_r[ERR_W-1], last_r});
      if (first_eff) begin
        acc_nxt    = '0;
        settle_nxt = '0;
      end
      if (restart_r) begin
        timeout_nxt = '0;
        arr_nxt     = 1'b0;
      end
    end

    if (ctrl.dterm) begin
      sum_nxt = prod_s;
      if (e_mag > {2'b0, int_zone_r}) begin
        acc_nxt = '0;
      end else if (s > lim) begin
        acc_nxt = lim[ACC_W-1:0];
      end else if (s < -lim) begin
        acc_nxt = ACC_W'(-lim);
      end else begin
        acc_nxt = s[ACC_W-1:0];
      end
    end

    if (ctrl.sign) begin
      sum_nxt  = sum_r + prod_s;
      d_ok_nxt = dmag <= {3'b0, deriv_tol_r};
      if ((acc_neg != e_r[ERR_W-1]) || (acc_zero != e_zero) || on_tgt) begin
        acc_nxt = '0;
      end
    end

    if (ctrl.iterm) begin
      if (on_tgt && d_ok_r) begin
        if (st >= TMR_W'(SETTLE_MS)) begin
          ar = 1'b1;
          st = '0;
        end else begin
          ar = 1'b0;
        end
        st = tmr_add(st);
      end
      if (tt >= TMR_W'(TIMEOUT_MS)) begin
        tt = '0;
        ar = 1'b1;
      end
      tt = tmr_add(tt);
      settle_nxt  = st;
      timeout_nxt = tt;
      arr_nxt     = ar;
    end

    if (ctrl.addi) begin
      sum_nxt = sum_r + prod_s;
    end

    if (ctrl.clamp) begin
      if (sum_r > dlim) begin
        sum_nxt = dlim;
      end else if (sum_r < -dlim) begin
        sum_nxt = -dlim;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      drive_lim_r <= '0;
      int_zone_r  <= '0;
      int_lim_r   <= '0;
      err_tol_r   <= '0;
      deriv_tol_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:    gain_p_r    <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r    <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r    <= cfg_wdata[GAIN_W-1:0];
        REG_DRIVE_LIM: drive_lim_r <= cfg_wdata[30:0];
        REG_INT_ZONE:  int_zone_r  <= cfg_wdata[14:0];
        REG_INT_LIM:   int_lim_r   <= cfg_wdata[22:0];
        REG_ERR_TOL:   err_tol_r   <= cfg_wdata[14:0];
        REG_DERIV_TOL: deriv_tol_r <= cfg_wdata[30:0];
        default:       gain_p_r    <= gain_p_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      first_r     <= 1'b1;
      acc_r       <= '0;
      settle_r    <= '0;
      timeout_r   <= '0;
      arr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      first_r     <= first_nxt;
      acc_r       <= acc_nxt;
      settle_r    <= settle_nxt;
      timeout_r   <= timeout_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r       <= in_if.error_sample;
      restart_r <= in_if.restart;
    end
    diff_r <= diff_nxt;
    sum_r  <= sum_nxt;
    d_ok_r <= d_ok_nxt;
    if (ctrl.finish) begin
      // floor of scaled sum over 256
      out_drive_r   <= prod_r[DRIVE_W+7:8];
      out_arrived_r <= arr_r;
    end
  end

endmodule
`default_nettype wire

>>> src/pwsd_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module pwsd_mul (
  input  wire logic                           clk,
  input  wire logic signed [pwsd_pkg::MA_W-1:0] a,
  input  wire logic signed [pwsd_pkg::MB_W-1:0] b,
  output logic signed [pwsd_pkg::MP_W-1:0]      prod_r
);
  import pwsd_pkg::*;

  logic signed [MP_W-1:0] prod_nxt;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

>>> src/pwsd_ctrl.sv
// sequencer stepping one request through the shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module pwsd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            out_free,
  output pwsd_pkg::ctrl_t      ctrl,
  output logic                 idle
);
  import pwsd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_DTERM;
      ST_DTERM: state_nxt = ST_SIGN;
      ST_SIGN:  state_nxt = ST_ITERM;
      ST_ITERM: state_nxt = ST_ADDI;
      ST_ADDI:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.msel = MSEL_P;
    idle = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
      end
      ST_PREP: begin
        ctrl.prep = 1'b1;
        ctrl.msel = MSEL_P;
      end
      ST_DTERM: begin
        ctrl.dterm = 1'b1;
        ctrl.msel  = MSEL_D;
      end
      ST_SIGN: begin
        ctrl.sign = 1'b1;
        ctrl.msel = MSEL_I;
      end
      ST_ITERM: begin
        ctrl.iterm = 1'b1;
        ctrl.msel  = MSEL_I;
      end
      ST_ADDI: begin
        ctrl.addi = 1'b1;
      end
      ST_CLAMP: begin
        ctrl.clamp = 1'b1;
      end
      ST_SCALE: begin
        ctrl.msel = MSEL_S;
      end
      ST_DONE: begin
        ctrl.msel   = MSEL_S;
        ctrl.finish = out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/pwsd_checker.sv
// checker on the top level ports, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module pwsd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // a waiting result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in flight: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a result never appears the cycle after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // reset leaves no result pending and the block ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

endmodule

bind pid_with_settle_detect pwsd_checker u_pwsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready)
);
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench for pid_with_settle_detect: drive and arrived flag checked against a local controller
module testbench;
  import pwsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          REPORT_LINES = 30;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      arrived;
  } tick_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  pwsd_in_if  in_ch();
  pwsd_out_if out_ch();

  pid_with_settle_detect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  longint      kp, ki, kd, drive_lim, int_zone, int_lim, err_tol, deriv_tol;
  longint      prev_err, acc;
  bit          fresh, arrived_now;
  int unsigned settle_t, timeout_t;

  tick_result_t expected_ticks[$];

  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned results_checked = 0;
  int unsigned arrivals_seen = 0;
  int unsigned settings_loaded = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic int unsigned bump_timer(input int unsigned t);
    return (t + TICK_MS > TIMER_MAX) ? int'(TIMER_MAX) : t + TICK_MS;
  endfunction

  task automatic clear_controller();
    prev_err    = 0;
    fresh       = 1'b1;
    acc         = 0;
    settle_t    = 0;
    timeout_t   = 0;
    arrived_now = 1'b0;
  endtask

  task automatic advance_controller(input logic signed [ERR_W-1:0] err, input logic clear_first);
    longint       e, p, d, it, total;
    bit           on_target;
    tick_result_t r;
    e = longint'(err);
    if (clear_first) clear_controller();
    p = kp * e;
    if (fresh) begin
      prev_err = e;
      acc      = 0;
      settle_t = 0;
      fresh    = 1'b0;
    end
    d = kd * (e - prev_err);
    prev_err = e;
    if (mag(e) > int_zone) begin
      acc = 0;
    end else begin
      acc = acc + e;
      if (acc > int_lim) acc = int_lim;
      else if (acc < -int_lim) acc = -int_lim;
    end
    on_target = mag(e) <= err_tol;
    if (sign_of(acc) != sign_of(e) || on_target) acc = 0;
    it = ki * acc;
    if (on_target && mag(d) <= deriv_tol) begin
      if (settle_t >= SETTLE_MS) begin
        arrived_now = 1'b1;
        settle_t    = 0;
      end else begin
        arrived_now = 1'b0;
      end
      settle_t = bump_timer(settle_t);
    end
    if (timeout_t >= TIMEOUT_MS) begin
      timeout_t   = 0;
      arrived_now = 1'b1;
    end
    timeout_t = bump_timer(timeout_t);
    total = p + it + d;
    if (total > drive_lim) total = drive_lim;
    else if (total < -drive_lim) total = -drive_lim;
    total = (total * OUT_SCALE_Q8) >>> 8;
    r.drive   = DRIVE_W'(total);
    r.arrived = arrived_now;
    expected_ticks.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:    kp = longint'($signed(val[GAIN_W-1:0]));
      REG_GAIN_I:    ki = longint'($signed(val[GAIN_W-1:0]));
      REG_GAIN_D:    kd = longint'($signed(val[GAIN_W-1:0]));
      REG_DRIVE_LIM: drive_lim = longint'(val);
      REG_INT_ZONE:  int_zone = longint'(val[14:0]);
      REG_INT_LIM:   int_lim = longint'(val[22:0]);
      REG_ERR_TOL:   err_tol = longint'(val[14:0]);
      REG_DERIV_TOL: deriv_tol = longint'(val);
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] g_p, input logic [CFG_W-1:0] g_i,
                               input logic [CFG_W-1:0] g_d, input logic [CFG_W-1:0] d_lim,
                               input logic [CFG_W-1:0] i_zone, input logic [CFG_W-1:0] i_lim,
                               input logic [CFG_W-1:0] e_tol, input logic [CFG_W-1:0] d_tol);
    write_reg(REG_GAIN_P, g_p);
    write_reg(REG_GAIN_I, g_i);
    write_reg(REG_GAIN_D, g_d);
    write_reg(REG_DRIVE_LIM, d_lim);
    write_reg(REG_INT_ZONE, i_zone);
    write_reg(REG_INT_LIM, i_lim);
    write_reg(REG_ERR_TOL, e_tol);
    write_reg(REG_DERIV_TOL, d_tol);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return CFG_W'(16'h8000);
      1: return CFG_W'(16'h7fff);
      2, 3, 4: return CFG_W'(16'(int'($urandom_range(0, 2048)) - 1024));
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_level(input int unsigned hi);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(hi);
      2, 3, 4: return CFG_W'($urandom_range(0, hi >> 8));
      default: return CFG_W'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [ERR_W-1:0] pick_error();
    int v;
    int m;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
      3, 4, 5: begin
        m = int'(int_zone) + 4;
        v = int'($urandom_range(0, 2 * m)) - m;
      end
      9: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: begin
        m = int'(err_tol) + 1;
        v = int'($urandom_range(0, 2 * m)) - m;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return ERR_W'(v);
  endfunction

  task automatic load_random_settings();
    load_settings(pick_gain(), pick_gain(), pick_gain(), pick_level(32'h7fffffff),
                  pick_level(32767), pick_level(8388607), pick_level(32767),
                  pick_level(32'h7fffffff));
  endtask

  task automatic send_tick(input logic signed [ERR_W-1:0] err, input logic clear_first);
    in_ch.valid        <= 1'b1;
    in_ch.error_sample <= err;
    in_ch.restart      <= clear_first;
    do @(posedge clk); while (!in_ch.ready);
    advance_controller(err, clear_first);
    ticks_sent++;
    if (clear_first) restarts_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_tick(16'h0000, 1'b0);
    send_tick(16'h7fff, 1'b0);
    send_tick(16'h8000, 1'b0);
    send_tick(16'h0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_extreme_gains();
    load_settings(31'h0007fff, 31'h0008000, 31'h0008000, 31'h7fffffff, 31'h0007fff,
                  31'h07fffff, 31'd0, 31'd0);
    send_tick(16'h8000, 1'b1);
    send_tick(16'h7fff, 1'b0);
    send_tick(16'h8000, 1'b0);
    send_tick(16'h7fff, 1'b0);
    send_tick(16'h0001, 1'b0);
    send_tick(16'h0002, 1'b0);
    send_tick(16'h0003, 1'b0);
    send_tick(16'h0000, 1'b0);
    send_tick(16'hffff, 1'b0);
    send_tick(16'hfff0, 1'b0);
    wait_idle();
  endtask

  task automatic test_zone_and_clamps();
    load_settings(31'h0000100, 31'h0000100, 31'h0000100, 31'd40000, 31'd100, 31'd150, 31'd5,
                  31'h7fffffff);
    send_tick(16'sd50, 1'b1);
    send_tick(16'sd60, 1'b0);
    send_tick(16'sd70, 1'b0);
    send_tick(16'sd200, 1'b0);
    send_tick(-16'sd3, 1'b0);
    send_tick(16'sd3, 1'b0);
    send_tick(16'sd40, 1'b0);
    send_tick(-16'sd80, 1'b0);
    send_tick(16'sd0, 1'b0);
    send_tick(-16'sd100, 1'b0);
    send_tick(-16'sd101, 1'b0);
    wait_idle();
  endtask

  task automatic test_settle_run();
    for (int round = 0; round < 2; round++) begin
      load_settings(31'h0000040, 31'h0000010, 31'h0000020, 31'h7fffffff, 31'd1024, 31'd4096,
                    31'd256, (round == 0) ? 31'h7fffffff : pick_level(32'h00ffffff));
      for (int i = 0; i < 45; i++)
        send_tick(ERR_W'(int'($urandom_range(0, 512)) - 256), i == 0);
      repeat (3) send_tick(ERR_W'($urandom_range(257, 32767)), 1'b0);
      repeat (4) send_tick(ERR_W'(int'($urandom_range(0, 512)) - 256), 1'b0);
      wait_idle();
    end
  endtask

  task automatic test_timeout_run();
    load_random_settings();
    for (int i = 0; i < 520; i++)
      send_tick(pick_error(), i == 0);
    wait_idle();
  endtask

  task automatic test_sender_pause();
    load_random_settings();
    repeat (4) begin
      repeat ($urandom_range(3, 10))
        send_tick(pick_error(), $urandom_range(0, 19) == 0);
      hold_until_drained();
    end
    wait_idle();
  endtask

  task automatic test_random_settings();
    repeat (6) begin
      load_random_settings();
      repeat (120)
        send_tick(pick_error(), $urandom_range(0, 39) == 0);
      wait_idle();
    end
  endtask

  task automatic test_steady_stream();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    load_random_settings();
    for (int i = 0; i < 100; i++)
      send_tick(pick_error(), i == 0 || $urandom_range(0, 49) == 0);
    wait_idle();
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("result without request", out_ch.drive, 0);
      end else begin
        want = expected_ticks.pop_front();
        if (out_ch.drive !== want.drive)
          report_mismatch("drive", out_ch.drive, want.drive);
        if (out_ch.arrived !== want.arrived)
          report_mismatch("arrived", out_ch.arrived, want.arrived);
        if (out_ch.arrived === 1'b1) arrivals_seen++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results pending",
               cycle_count, expected_ticks.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_GAIN_P;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.error_sample <= '0;
    in_ch.restart      <= 1'b0;
    kp = 0; ki = 0; kd = 0; drive_lim = 0;
    int_zone = 0; int_lim = 0; err_tol = 0; deriv_tol = 0;
    clear_controller();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_extreme_gains();
    test_zone_and_clamps();
    test_settle_run();
    test_timeout_run();
    test_sender_pause();
    test_random_settings();
    test_steady_stream();

    if (expected_ticks.size() != 0)
      report_mismatch("missing results", 0, expected_ticks.size());
    $display("sent %0d control ticks (%0d with restart) across %0d register settings",
             ticks_sent, restarts_sent, settings_loaded);
    $display("checked %0d results, %0d with arrived set, %0d mismatches",
             results_checked, arrivals_seen, mismatches);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> pid_with_settle_detect.f
src/pwsd_pkg.sv
src/pwsd_in_if.sv
src/pwsd_out_if.sv
src/pwsd_mul.sv
src/pwsd_ctrl.sv
src/pid_with_settle_detect.sv
src/pwsd_checker.sv
tb/testbench.sv
